// File: design/binary_to_decimal_ascii_core_defines.svh
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define B2DA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int SAT_BITS    = 34;
  localparam int MAX_DIGITS  = 10;
  localparam int BCD_BITS    = 4 * MAX_DIGITS;
  localparam int DIGIT_IDX_W = 4;

  localparam logic [SAT_BITS-1:0]    SATURATED_VALUE = 34'd9999999999;
  localparam logic [DIGIT_IDX_W-1:0] TOP_DIGIT       = 4'd9;
  localparam logic [1:0]             ASCII_ZERO_HI   = 2'b11;  // '0' is 6'b110000

  typedef struct packed {
    logic load;   // take a new value, clear the BCD register
    logic shift;  // one add-3 / shift step
    logic prep;   // latch the index of the leading digit
    logic emit;   // move one digit into the output register
  } b2da_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic last;
    logic out_free;
  } b2da_sts_t;

endpackage

// File: design/b2da_dp.sv
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_core_defines.svh"

module b2da_dp #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value,
  input  b2da_pkg::b2da_cmd_t   cmd_i,
  output b2da_pkg::b2da_sts_t   sts_o,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_char,
  output logic                  out_last
);

  localparam int WORK_BITS = (VALUE_BITS > b2da_pkg::SAT_BITS) ? b2da_pkg::SAT_BITS
                                                               : VALUE_BITS;
  localparam int CNT_W     = $clog2(WORK_BITS + 1);

  logic [WORK_BITS-1:0]              sat_val;
  logic [WORK_BITS-1:0]              shift_r, shift_nxt;
  logic [b2da_pkg::BCD_BITS-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [b2da_pkg::DIGIT_IDX_W-1:0]  idx_r, idx_nxt, top_idx;
  logic [3:0]                        cur_digit;
  logic                              out_valid_r, out_valid_nxt;
  logic [5:0]                        out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;

  generate
    if (VALUE_BITS >= b2da_pkg::SAT_BITS) begin : g_sat
      assign sat_val = (in_value > VALUE_BITS'(b2da_pkg::SATURATED_VALUE))
                       ? WORK_BITS'(b2da_pkg::SATURATED_VALUE)
                       : in_value[WORK_BITS-1:0];
    end else begin : g_nosat
      assign sat_val = in_value;
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < b2da_pkg::MAX_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 1; i < b2da_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top_idx = b2da_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[{idx_r, 2'b00} +: 4];

  always_comb begin
    shift_nxt     = shift_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd_i.load) begin
      shift_nxt = sat_val;
      bcd_nxt   = '0;
      cnt_nxt   = CNT_W'(WORK_BITS);
    end else if (cmd_i.shift) begin
      shift_nxt = shift_r << 1;
      bcd_nxt   = {bcd_adj[b2da_pkg::BCD_BITS-2:0], shift_r[WORK_BITS-1]};
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
    if (cmd_i.prep) begin
      idx_nxt = top_idx;
    end else if (cmd_i.emit) begin
      idx_nxt = idx_r - b2da_pkg::DIGIT_IDX_W'(1);
    end
    if (cmd_i.emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = {b2da_pkg::ASCII_ZERO_HI, cur_digit};
      out_last_nxt  = (idx_r == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts_o.conv_done = (cnt_r == '0);
  assign sts_o.last      = (idx_r == '0);
  assign sts_o.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `B2DA_ASSERT_NEXT(a_load_count, cmd_i.load, cnt_r == CNT_W'(WORK_BITS), "bad step count")
  `B2DA_ASSERT_IMPL(a_idx_range, cmd_i.emit, idx_r <= b2da_pkg::TOP_DIGIT, "digit index range")
  `B2DA_ASSERT_NEXT(a_no_lead_zero, cmd_i.prep, (cur_digit != 4'd0) || (idx_r == '0), "leading zero")

endmodule

// File: design/b2da_ctrl.sv
`timescale 1ns / 1ps

module b2da_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b2da_pkg::b2da_sts_t sts_i,
  output b2da_pkg::b2da_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.conv_done) begin
          cmd_o.prep = 1'b1;
          state_nxt  = ST_EMIT;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// Sequence: an input transaction loads the value, WORK_BITS add-3/shift steps follow
//   (WORK_BITS = min(VALUE_BITS, 34)), then the leading digit index is latched.
// Flow: the bit-serial converter accepts a new value only when idle, after the previous
//   value's last digit is emitted; digits leave one per cycle while out_tready is high.
// Reset: synchronous active-low rst_n clears the controller and output valid.

module binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = 31
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    in_tdata,   // [VALUE_BITS-1:0] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [5:0] digit_char
  output logic                               out_tlast   // last_digit
);

  b2da_pkg::b2da_cmd_t cmd;
  b2da_pkg::b2da_sts_t sts;
  logic [5:0]          out_char;

  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  b2da_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_tdata[VALUE_BITS-1:0]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_char};

endmodule

// File: verif/binary_to_decimal_ascii_core_test.sv
`timescale 1ns / 1ps

module binary_to_decimal_ascii_core_test;

  localparam int VALUE_BITS = 31;
  localparam int WORD_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam logic [5:0] DIGIT_ZERO = 6'd48;  // '0'
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } digit_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [WORD_BITS-1:0] in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tlast;

  digit_t pending_digits[$];
  int     mismatches = 0;
  int     in_idle_max = 9;
  int     out_idle_max = 9;

  binary_to_decimal_ascii_core #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decimal digits of the low VALUE_BITS bits (clamped to SATURATED_VALUE), most significant first.
  function automatic void queue_decimal_digits(input logic [WORD_BITS-1:0] word);
    longint unsigned v;
    logic [3:0]      rev[b2da_pkg::MAX_DIGITS];
    int              n;
    int              k;
    digit_t          d;
    v = longint'(word[VALUE_BITS-1:0]);
    if (v > longint'(b2da_pkg::SATURATED_VALUE))
      v = longint'(b2da_pkg::SATURATED_VALUE);
    n = 0;
    do begin
      rev[n] = 4'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0 && n < b2da_pkg::MAX_DIGITS);
    for (k = n - 1; k >= 0; k--) begin
      d.code = DIGIT_ZERO + 6'(rev[k]);
      d.last = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  task automatic send_value(input logic [WORD_BITS-1:0] word);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    queue_decimal_digits(word);
  endtask

  // Value with a random number of decimal digits, sometimes with random padding bits above VALUE_BITS.
  function automatic logic [WORD_BITS-1:0] draw_value();
    longint unsigned lo;
    longint unsigned hi;
    int              nd;
    int              k;
    logic [WORD_BITS-1:0] word;
    nd = $urandom_range(1, 10);
    lo = 1;
    for (k = 1; k < nd; k++)
      lo = lo * 10;
    hi = (nd == 1) ? 9 : lo * 10 - 1;
    if (nd == 1)
      lo = 0;
    if (hi > VALUE_MAX)
      hi = VALUE_MAX;
    word = WORD_BITS'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    if ($urandom_range(0, 3) == 0)
      word[WORD_BITS-1:VALUE_BITS] = (WORD_BITS - VALUE_BITS)'($urandom);
    return word;
  endfunction

  task automatic test_edge_values();
    longint unsigned p;
    p = 1;
    send_value(0);
    send_value(WORD_BITS'(VALUE_MAX));
    send_value(9);
    repeat (9) begin
      send_value(WORD_BITS'(p * 10 - 1));
      p = p * 10;
      send_value(WORD_BITS'(p));
    end
    send_value(WORD_BITS'(32'h5555_5555 & VALUE_MAX));
    send_value(32'h2AAA_AAAA);
  endtask

  task automatic test_padding_ignored();
    send_value({{(WORD_BITS - VALUE_BITS){1'b1}}, {VALUE_BITS{1'b0}}});
    send_value({{(WORD_BITS - VALUE_BITS){1'b1}}, VALUE_BITS'(12345)});
    send_value({WORD_BITS{1'b1}});
  endtask

  task automatic test_back_to_back();
    in_idle_max  = 0;
    out_idle_max = 0;
    repeat (30)
      send_value(draw_value());
    in_idle_max  = 9;
    out_idle_max = 9;
  endtask

  task automatic test_random_traffic();
    repeat (11) begin
      in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 9;
      out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      repeat (20) begin
        if ($urandom_range(0, 1))
          send_value(draw_value());
        else
          send_value($urandom);
      end
    end
    in_idle_max  = 9;
    out_idle_max = 9;
  endtask

  initial begin : digit_sink
    digit_t want;
    int     gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, out_idle_max);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_digits.size() == 0) begin
        $error("unexpected transaction: digit_char %0d last_digit %0b",
               out_tdata[5:0], out_tlast);
        mismatches++;
      end else begin
        want = pending_digits.pop_front();
        if (out_tdata[5:0] !== want.code) begin
          $error("digit_char: expected %0d, actual %0d", want.code, out_tdata[5:0]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_digit: expected %0b, actual %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_values();
    test_padding_ignored();
    test_back_to_back();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_digits.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_digits.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
